/* hdl/rfps_pkg.sv */
// ----------------------------------------------------------------------------
// Flight phase sequencer package
// Types, register indexes, reset values and phase encodings shared by the
// flight phase sequencer and its checker.
// ----------------------------------------------------------------------------
package rfps_pkg;

  // Widths of the item fields and registers.
  localparam int unsigned AltW      = 25;
  localparam int unsigned SensW     = 16;
  localparam int unsigned CntW      = 4;
  localparam int unsigned FlagW     = 8;
  localparam int unsigned PhaseW    = 4;
  localparam int unsigned CfgDataW  = 20;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_LIFTOFF_ACCEL  = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIFTOFF_TICKS  = 4'd1;
  localparam logic [CfgIdxW-1:0] CFG_BURNOUT_ACCEL  = 4'd2;
  localparam logic [CfgIdxW-1:0] CFG_TILT_LIMIT     = 4'd3;
  localparam logic [CfgIdxW-1:0] CFG_APOGEE_MIN_ALT = 4'd4;
  localparam logic [CfgIdxW-1:0] CFG_APOGEE_TICKS   = 4'd5;
  localparam logic [CfgIdxW-1:0] CFG_DROGUE_ALT     = 4'd6;
  localparam logic [CfgIdxW-1:0] CFG_MAIN_ALT       = 4'd7;

  // Landing window: near 1 g and close to the ground.
  localparam logic signed [SensW-1:0] LAND_ACCEL_LOW  = 16'sd900;
  localparam logic signed [SensW-1:0] LAND_ACCEL_HIGH = 16'sd1100;
  localparam logic signed [AltW-1:0]  LAND_ALT_MAX    = 25'sd1000;

  // Status bit positions.
  localparam int unsigned ST_LIFTOFF     = 0;
  localparam int unsigned ST_BURNOUT     = 1;
  localparam int unsigned ST_DROGUE_PASS = 2;
  localparam int unsigned ST_TILT        = 3;
  localparam int unsigned ST_DESCENT     = 4;
  localparam int unsigned ST_DROGUE_CMD  = 5;
  localparam int unsigned ST_UNUSED      = 6;
  localparam int unsigned ST_MAIN_CMD    = 7;

  // Phase codes as reported on the result.
  localparam logic [PhaseW-1:0] PH_CODE_IDLE    = 4'd0;
  localparam logic [PhaseW-1:0] PH_CODE_LIFTOFF = 4'd1;
  localparam logic [PhaseW-1:0] PH_CODE_BURNOUT = 4'd2;
  localparam logic [PhaseW-1:0] PH_CODE_COAST   = 4'd3;
  localparam logic [PhaseW-1:0] PH_CODE_APOGEE  = 4'd4;
  localparam logic [PhaseW-1:0] PH_CODE_DESCENT = 4'd5;
  localparam logic [PhaseW-1:0] PH_CODE_DROGUE  = 4'd6;
  localparam logic [PhaseW-1:0] PH_CODE_MAIN    = 4'd7;
  localparam logic [PhaseW-1:0] PH_CODE_LANDED  = 4'd8;

  // Flight phase state, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE    = 9'b000000001,
    PH_LIFTOFF = 9'b000000010,
    PH_BURNOUT = 9'b000000100,
    PH_COAST   = 9'b000001000,
    PH_APOGEE  = 9'b000010000,
    PH_DESCENT = 9'b000100000,
    PH_DROGUE  = 9'b001000000,
    PH_MAIN    = 9'b010000000,
    PH_LANDED  = 9'b100000000
  } phase_e;

  // Configuration register file.
  typedef struct packed {
    logic [13:0] liftoff_accel_limit;
    logic [3:0]  liftoff_confirm_ticks;
    logic [13:0] burnout_accel_limit;
    logic [14:0] tilt_limit;
    logic [19:0] apogee_min_altitude;
    logic [3:0]  apogee_confirm_ticks;
    logic [19:0] drogue_altitude;
    logic [19:0] main_altitude;
  } cfg_t;

  // One sensor tick.
  typedef struct packed {
    logic signed [AltW-1:0]  altitude_cm;
    logic signed [SensW-1:0] accel_vertical_mg;
    logic signed [SensW-1:0] pitch_centideg;
    logic signed [SensW-1:0] roll_centideg;
    logic                    pressure_ok;
    logic                    accel_ok;
  } item_t;

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    phase_e                 phase;
    logic signed [AltW-1:0] last_alt;
    logic [CntW-1:0]        liftoff_cnt;
    logic [CntW-1:0]        apogee_cnt;
    logic [FlagW-1:0]       flags;
  } state_t;

  // Saturating increment of a tick counter.
  function automatic logic [CntW-1:0] bump(input logic [CntW-1:0] c);
    logic [CntW-1:0] r;
    r = (c == {CntW{1'b1}}) ? c : c + 1'b1;
    return r;
  endfunction

  // Numeric phase code of a one-hot phase.
  function automatic logic [PhaseW-1:0] phase_code(input phase_e ph);
    logic [PhaseW-1:0] r;
    unique case (ph)
      PH_IDLE:    r = PH_CODE_IDLE;
      PH_LIFTOFF: r = PH_CODE_LIFTOFF;
      PH_BURNOUT: r = PH_CODE_BURNOUT;
      PH_COAST:   r = PH_CODE_COAST;
      PH_APOGEE:  r = PH_CODE_APOGEE;
      PH_DESCENT: r = PH_CODE_DESCENT;
      PH_DROGUE:  r = PH_CODE_DROGUE;
      PH_MAIN:    r = PH_CODE_MAIN;
      PH_LANDED:  r = PH_CODE_LANDED;
      default:    r = PH_CODE_IDLE;
    endcase
    return r;
  endfunction

endpackage

/* hdl/rfps_step.sv */
// ----------------------------------------------------------------------------
// Flight phase step logic
// Combinational next-state logic: takes the current sequencer state, the
// configuration and one sensor item and gives the state after that item.
// ----------------------------------------------------------------------------
module rfps_step (
  input  rfps_pkg::state_t cur_i,
  input  rfps_pkg::cfg_t   cfg_i,
  input  rfps_pkg::item_t  item_i,
  output rfps_pkg::state_t nxt_o
);

  logic                valid_tick;
  logic                falling;
  logic signed [16:0]  az_ext;
  logic signed [16:0]  pitch_ext;
  logic signed [16:0]  roll_ext;
  logic signed [25:0]  alt_ext;
  logic                lo_above;
  logic                bo_below;
  logic                tilt;
  logic                ap_above;
  logic                at_drogue;
  logic                at_main;
  logic                landed;
  logic [rfps_pkg::CntW-1:0] lo_inc;
  logic [rfps_pkg::CntW-1:0] ap_inc;

  // Sign-extended operands so that signed fields compare with unsigned limits.
  assign valid_tick = item_i.pressure_ok & item_i.accel_ok;
  assign az_ext     = {item_i.accel_vertical_mg[15], item_i.accel_vertical_mg};
  assign pitch_ext  = {item_i.pitch_centideg[15], item_i.pitch_centideg};
  assign roll_ext   = {item_i.roll_centideg[15], item_i.roll_centideg};
  assign alt_ext    = {item_i.altitude_cm[24], item_i.altitude_cm};

  // Threshold comparisons of this tick.
  assign falling   = item_i.altitude_cm < cur_i.last_alt;
  assign lo_above  = az_ext > $signed({3'b000, cfg_i.liftoff_accel_limit});
  assign bo_below  = az_ext < $signed({3'b000, cfg_i.burnout_accel_limit});
  assign tilt      = (pitch_ext > $signed({2'b00, cfg_i.tilt_limit}))
                   | (roll_ext  > $signed({2'b00, cfg_i.tilt_limit}));
  assign ap_above  = alt_ext > $signed({6'b000000, cfg_i.apogee_min_altitude});
  assign at_drogue = alt_ext <= $signed({6'b000000, cfg_i.drogue_altitude});
  assign at_main   = alt_ext <= $signed({6'b000000, cfg_i.main_altitude});
  assign landed    = (item_i.accel_vertical_mg > rfps_pkg::LAND_ACCEL_LOW)
                   & (item_i.accel_vertical_mg < rfps_pkg::LAND_ACCEL_HIGH)
                   & (item_i.altitude_cm < rfps_pkg::LAND_ALT_MAX);

  assign lo_inc = rfps_pkg::bump(cur_i.liftoff_cnt);
  assign ap_inc = rfps_pkg::bump(cur_i.apogee_cnt);

  // Phase transitions; an invalid tick leaves everything as it is.
  always_comb begin
    nxt_o = cur_i;
    if (valid_tick) begin
      nxt_o.last_alt = item_i.altitude_cm;
      unique case (cur_i.phase)
        rfps_pkg::PH_IDLE: begin
          if (lo_above) begin
            nxt_o.liftoff_cnt = lo_inc;
            if (lo_inc >= cfg_i.liftoff_confirm_ticks) begin
              nxt_o.phase                       = rfps_pkg::PH_LIFTOFF;
              nxt_o.flags[rfps_pkg::ST_LIFTOFF] = 1'b1;
              nxt_o.liftoff_cnt                 = '0;
            end
          end else begin
            nxt_o.liftoff_cnt = '0;
          end
        end
        rfps_pkg::PH_LIFTOFF: begin
          if (bo_below) begin
            nxt_o.phase                       = rfps_pkg::PH_BURNOUT;
            nxt_o.flags[rfps_pkg::ST_BURNOUT] = 1'b1;
          end
          if (tilt) begin
            nxt_o.flags[rfps_pkg::ST_TILT] = 1'b1;
          end
        end
        rfps_pkg::PH_BURNOUT: begin
          nxt_o.phase = rfps_pkg::PH_COAST;
        end
        rfps_pkg::PH_COAST: begin
          if (ap_above && falling) begin
            nxt_o.apogee_cnt = ap_inc;
            if (ap_inc >= cfg_i.apogee_confirm_ticks) begin
              nxt_o.phase      = rfps_pkg::PH_APOGEE;
              nxt_o.apogee_cnt = '0;
            end
          end else if (!falling) begin
            nxt_o.apogee_cnt = '0;
          end
        end
        rfps_pkg::PH_APOGEE: begin
          nxt_o.phase                       = rfps_pkg::PH_DESCENT;
          nxt_o.flags[rfps_pkg::ST_DESCENT] = 1'b1;
        end
        rfps_pkg::PH_DESCENT: begin
          if (at_drogue) begin
            nxt_o.phase                          = rfps_pkg::PH_DROGUE;
            nxt_o.flags[rfps_pkg::ST_DROGUE_CMD] = 1'b1;
          end
        end
        rfps_pkg::PH_DROGUE: begin
          nxt_o.flags[rfps_pkg::ST_DROGUE_PASS] = 1'b1;
          if (at_main) begin
            nxt_o.phase                        = rfps_pkg::PH_MAIN;
            nxt_o.flags[rfps_pkg::ST_MAIN_CMD] = 1'b1;
          end
        end
        rfps_pkg::PH_MAIN: begin
          if (landed) begin
            nxt_o.phase = rfps_pkg::PH_LANDED;
          end
        end
        default: begin
          nxt_o.phase = cur_i.phase;
        end
      endcase
    end
  end

endmodule

/* hdl/rocket_flight_phase_sequencer.sv */
// ----------------------------------------------------------------------------
// Rocket flight phase sequencer
// Steps a nine-phase recovery state machine, one sensor item at a time, and
// reports the phase and sticky status flags for every item.
// ----------------------------------------------------------------------------
// The block takes one sensor item per clock cycle while the result stream is
// not stalled, and returns exactly one result per item, in order. An accepted
// item is held in an input register; the step logic then updates the flight
// state and loads the result register once that register is free or being
// emptied. The pair of registers lets a new item be accepted while a finished
// result still waits, and the single state update per cycle sets the
// sustained rate of one item per cycle. Items with either valid flag low
// leave the state untouched and report the current phase and flags.
// Configuration registers should be written only while no item is in flight.
module rocket_flight_phase_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [rfps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rfps_pkg::CfgDataW-1:0]  cfg_data_i,
  // Sensor items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // altitude_cm[24:0], accel_vertical_mg[40:25], pitch_centideg[56:41],
  // roll_centideg[72:57], zero fill [79:73]
  input  logic [rfps_pkg::InDataW-1:0]   s_axis_tdata,
  // pressure_ok[0], accel_ok[1]
  input  logic [rfps_pkg::InUserW-1:0]   s_axis_tuser,
  // Results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // flight_phase[3:0], status_bits[11:4], zero fill [15:12]
  output logic [rfps_pkg::OutDataW-1:0]  m_axis_tdata
);

  rfps_pkg::cfg_t   cfg_q;
  rfps_pkg::item_t  in_q;
  logic             in_valid_q;
  rfps_pkg::state_t state_q;
  rfps_pkg::state_t state_d;
  logic             out_valid_q;
  logic [rfps_pkg::PhaseW-1:0] out_phase_q;
  logic [rfps_pkg::FlagW-1:0]  out_flags_q;
  logic             advance;
  logic             in_take;

  // Handshake: the input register moves on whenever the result register is
  // free or being emptied in the same cycle.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  // Configuration registers, masked to their widths; other indexes ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.liftoff_accel_limit   <= 14'd2500;
      cfg_q.liftoff_confirm_ticks <= 4'd3;
      cfg_q.burnout_accel_limit   <= 14'd1200;
      cfg_q.tilt_limit            <= 15'd3000;
      cfg_q.apogee_min_altitude   <= 20'd5000;
      cfg_q.apogee_confirm_ticks  <= 4'd5;
      cfg_q.drogue_altitude       <= 20'd30000;
      cfg_q.main_altitude         <= 20'd10000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfps_pkg::CFG_LIFTOFF_ACCEL:  cfg_q.liftoff_accel_limit   <= cfg_data_i[13:0];
        rfps_pkg::CFG_LIFTOFF_TICKS:  cfg_q.liftoff_confirm_ticks <= cfg_data_i[3:0];
        rfps_pkg::CFG_BURNOUT_ACCEL:  cfg_q.burnout_accel_limit   <= cfg_data_i[13:0];
        rfps_pkg::CFG_TILT_LIMIT:     cfg_q.tilt_limit            <= cfg_data_i[14:0];
        rfps_pkg::CFG_APOGEE_MIN_ALT: cfg_q.apogee_min_altitude   <= cfg_data_i;
        rfps_pkg::CFG_APOGEE_TICKS:   cfg_q.apogee_confirm_ticks  <= cfg_data_i[3:0];
        rfps_pkg::CFG_DROGUE_ALT:     cfg_q.drogue_altitude       <= cfg_data_i;
        rfps_pkg::CFG_MAIN_ALT:       cfg_q.main_altitude         <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload, unpacked from the stream fields.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.altitude_cm       <= s_axis_tdata[24:0];
      in_q.accel_vertical_mg <= s_axis_tdata[40:25];
      in_q.pitch_centideg    <= s_axis_tdata[56:41];
      in_q.roll_centideg     <= s_axis_tdata[72:57];
      in_q.pressure_ok       <= s_axis_tuser[0];
      in_q.accel_ok          <= s_axis_tuser[1];
    end
  end

  // Next-state logic for the held item.
  rfps_step u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .item_i (in_q),
    .nxt_o  (state_d)
  );

  // Flight state, updated once per item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= rfps_pkg::PH_IDLE;
      state_q.last_alt    <= '0;
      state_q.liftoff_cnt <= '0;
      state_q.apogee_cnt  <= '0;
      state_q.flags       <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_phase_q <= rfps_pkg::phase_code(state_d.phase);
      out_flags_q <= state_d.flags;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_flags_q, out_phase_q};

endmodule

/* hdl/rfps_checker.sv */
// ----------------------------------------------------------------------------
// Flight phase sequencer checker
// Port-level checks on the result stream: stalled results hold, phases only
// move forward, status flags never clear and the unused bit is never set.
// ----------------------------------------------------------------------------
module rfps_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rfps_pkg::OutDataW-1:0] m_axis_tdata
);

  logic                        out_take;
  logic [rfps_pkg::PhaseW-1:0] last_phase_q;
  logic [rfps_pkg::FlagW-1:0]  last_flags_q;

  assign out_take = m_axis_tvalid & m_axis_tready;

  // Phase and flags of the last result taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= rfps_pkg::PH_CODE_IDLE;
      last_flags_q <= '0;
    end else if (out_take) begin
      last_phase_q <= m_axis_tdata[3:0];
      last_flags_q <= m_axis_tdata[11:4];
    end
  end

  // A stalled result stays put.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The unused status bit is never set.
  a_unused_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[4 + rfps_pkg::ST_UNUSED])
    else $error("unused status bit set");

  // Status flags are sticky from one result to the next.
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[11:4] & last_flags_q) == last_flags_q)
    else $error("status flag cleared");

  // The flight phase never moves backwards.
  a_phase_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] >= last_phase_q)
    else $error("flight phase went backwards");

endmodule

bind rocket_flight_phase_sequencer rfps_checker u_rfps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_rocket_flight_phase_sequencer.sv */
// ----------------------------------------------------------------------------
// Flight phase sequencer testbench
// Flies one complete flight through the sequencer, from idle to landed, with
// long stays in every phase but burnout and apogee, and checks the phase and
// sticky status flags of every result against a cycle-free model of the
// state machine. The sensor and result streams idle at random, and the
// registers are retuned between stages whenever nothing is in flight.
// ----------------------------------------------------------------------------
module tb_rocket_flight_phase_sequencer;
  import rfps_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldTicks  = 47;

  // Model of the sequencer state, with the phase as its reported code.
  typedef struct packed {
    logic [PhaseW-1:0]      phase;
    logic signed [AltW-1:0] last_alt;
    logic [CntW-1:0]        lift_cnt;
    logic [CntW-1:0]        apo_cnt;
    logic [FlagW-1:0]       flags;
  } flight_t;

  // One expected result.
  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [FlagW-1:0]  flags;
  } status_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i     = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic [InUserW-1:0]    s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;

  item_t   tx_item   = '0;
  cfg_t    model_cfg;
  flight_t model_st  = '0;
  flight_t steer     = '0;
  item_t   pending_q[$];
  status_t due_q[$];
  int      n_sent      = 0;
  int      n_taken     = 0;
  int      errors      = 0;
  int      idle_cycles = 0;
  bit      calm        = 1'b0;

  always #5 clk_i = ~clk_i;

  // altitude_cm, accel_vertical_mg, pitch_centideg, roll_centideg, zero fill
  assign s_axis_tdata = {{(InDataW - AltW - 3 * SensW){1'b0}}, tx_item.roll_centideg,
                         tx_item.pitch_centideg, tx_item.accel_vertical_mg,
                         tx_item.altitude_cm};
  // pressure_ok, accel_ok
  assign s_axis_tuser = {tx_item.accel_ok, tx_item.pressure_ok};

  rocket_flight_phase_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Random integer in the closed range lo to hi.
  function automatic int spread(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Tick counter that sticks at its top value.
  function automatic logic [CntW-1:0] tick_up(input logic [CntW-1:0] c);
    return (c == {CntW{1'b1}}) ? c : c + 1'b1;
  endfunction

  // One step of the flight state machine for one sensor item.
  function automatic flight_t advance_flight(input flight_t s, input cfg_t c, input item_t t);
    flight_t nxt;
    int      alt, last, az, pit, rol;
    int      lim_lift, lim_burn, lim_tilt, min_apo, alt_drogue, alt_main;
    int      land_lo, land_hi, land_alt;
    logic    falling;
    nxt        = s;
    alt        = $signed(t.altitude_cm);
    last       = $signed(s.last_alt);
    az         = $signed(t.accel_vertical_mg);
    pit        = $signed(t.pitch_centideg);
    rol        = $signed(t.roll_centideg);
    lim_lift   = c.liftoff_accel_limit;
    lim_burn   = c.burnout_accel_limit;
    lim_tilt   = c.tilt_limit;
    min_apo    = c.apogee_min_altitude;
    alt_drogue = c.drogue_altitude;
    alt_main   = c.main_altitude;
    land_lo    = LAND_ACCEL_LOW;
    land_hi    = LAND_ACCEL_HIGH;
    land_alt   = LAND_ALT_MAX;
    // An item with either reading invalid leaves everything as it is.
    if (t.pressure_ok && t.accel_ok) begin
      falling      = alt < last;
      nxt.last_alt = t.altitude_cm;
      case (s.phase)
        PH_CODE_IDLE: begin
          if (az > lim_lift) begin
            nxt.lift_cnt = tick_up(s.lift_cnt);
            if (nxt.lift_cnt >= c.liftoff_confirm_ticks) begin
              nxt.phase              = PH_CODE_LIFTOFF;
              nxt.flags[ST_LIFTOFF]  = 1'b1;
              nxt.lift_cnt           = '0;
            end
          end else begin
            nxt.lift_cnt = '0;
          end
        end
        PH_CODE_LIFTOFF: begin
          if (az < lim_burn) begin
            nxt.phase             = PH_CODE_BURNOUT;
            nxt.flags[ST_BURNOUT] = 1'b1;
          end
          if (pit > lim_tilt || rol > lim_tilt) nxt.flags[ST_TILT] = 1'b1;
        end
        PH_CODE_BURNOUT: nxt.phase = PH_CODE_COAST;
        PH_CODE_COAST: begin
          // A falling item at or below the floor keeps the count.
          if (alt > min_apo && falling) begin
            nxt.apo_cnt = tick_up(s.apo_cnt);
            if (nxt.apo_cnt >= c.apogee_confirm_ticks) begin
              nxt.phase   = PH_CODE_APOGEE;
              nxt.apo_cnt = '0;
            end
          end else if (!falling) begin
            nxt.apo_cnt = '0;
          end
        end
        PH_CODE_APOGEE: begin
          nxt.phase             = PH_CODE_DESCENT;
          nxt.flags[ST_DESCENT] = 1'b1;
        end
        PH_CODE_DESCENT: begin
          if (alt <= alt_drogue) begin
            nxt.phase                = PH_CODE_DROGUE;
            nxt.flags[ST_DROGUE_CMD] = 1'b1;
          end
        end
        PH_CODE_DROGUE: begin
          nxt.flags[ST_DROGUE_PASS] = 1'b1;
          if (alt <= alt_main) begin
            nxt.phase              = PH_CODE_MAIN;
            nxt.flags[ST_MAIN_CMD] = 1'b1;
          end
        end
        PH_CODE_MAIN: begin
          if (az > land_lo && az < land_hi && alt < land_alt) nxt.phase = PH_CODE_LANDED;
        end
        default: ;
      endcase
    end
    return nxt;
  endfunction

  // Builds one sensor item from plain integers.
  function automatic item_t sensor_tick(input int alt, input int az, input int pit,
                                        input int rol, input bit pok, input bit aok);
    item_t t;
    t.altitude_cm       = alt[AltW-1:0];
    t.accel_vertical_mg = az[SensW-1:0];
    t.pitch_centideg    = pit[SensW-1:0];
    t.roll_centideg     = rol[SensW-1:0];
    t.pressure_ok       = pok;
    t.accel_ok          = aok;
    return t;
  endfunction

  // Turns some items into invalid ones or into raw noise.
  function automatic item_t spoil(input item_t t, input int noise_pct);
    item_t   u;
    int      r;
    int unsigned f;
    u = t;
    r = $urandom_range(99);
    f = $urandom_range(2);
    if (r < noise_pct) begin
      u.pressure_ok = f[1];
      u.accel_ok    = f[0];
    end else if (r < noise_pct + 5) begin
      u = sensor_tick($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
    end
    return u;
  endfunction

  // An item that stays close to the thresholds of the current phase.
  function automatic item_t dwell_candidate(input flight_t s);
    int alt, az, pit, rol, last, tilt;
    last = $signed(s.last_alt);
    tilt = model_cfg.tilt_limit;
    alt  = last + spread(-200, 200);
    az   = spread(-1000, 3000);
    pit  = spread(-18000, 18000);
    rol  = spread(-18000, 18000);
    case (s.phase)
      PH_CODE_IDLE: az = int'(model_cfg.liftoff_accel_limit) + spread(-3, 3);
      PH_CODE_LIFTOFF: begin
        az  = int'(model_cfg.burnout_accel_limit) + spread(0, 2000);
        pit = tilt - spread(1, 18000);
        rol = tilt - spread(1, 18000);
        if ($urandom_range(19) == 0) pit = tilt + spread(-1, 1);
        if ($urandom_range(19) == 0) rol = tilt + spread(-1, 1);
      end
      PH_CODE_COAST: begin
        if ($urandom_range(1)) alt = int'(model_cfg.apogee_min_altitude) + spread(-300, 300);
      end
      PH_CODE_DESCENT: alt = int'(model_cfg.drogue_altitude) + spread(-2, 3000);
      PH_CODE_DROGUE:  alt = int'(model_cfg.main_altitude) + spread(-2, 3000);
      PH_CODE_MAIN: begin
        az  = spread(895, 1105);
        alt = $urandom_range(1) ? spread(990, 1010) : spread(-100000, 200000);
      end
      default: alt = spread(-100000, 10000000);
    endcase
    return spoil(sensor_tick(alt, az, pit, rol, 1'b1, 1'b1), 8);
  endfunction

  // An item that pushes the flight on towards the next phase.
  function automatic item_t climb_candidate(input flight_t s);
    int alt, az, last, apo;
    last = $signed(s.last_alt);
    apo  = model_cfg.apogee_min_altitude;
    alt  = spread(-100000, 10000000);
    az   = spread(-32768, 32767);
    case (s.phase)
      PH_CODE_IDLE:    az = int'(model_cfg.liftoff_accel_limit) + spread(1, 3000);
      PH_CODE_LIFTOFF: az = int'(model_cfg.burnout_accel_limit) - spread(1, 500);
      PH_CODE_COAST:   alt = (last <= apo + 200) ? apo + spread(3000, 5000)
                                                 : last - spread(1, 150);
      PH_CODE_DESCENT: alt = int'(model_cfg.drogue_altitude) - spread(0, 100);
      PH_CODE_DROGUE:  alt = int'(model_cfg.main_altitude) - spread(0, 100);
      PH_CODE_MAIN: begin
        az  = spread(901, 1099);
        alt = spread(-1000, 999);
      end
      default: ;
    endcase
    return spoil(sensor_tick(alt, az, spread(-18000, 18000), spread(-18000, 18000),
                             1'b1, 1'b1), 10);
  endfunction

  // Queues an item and tracks where the flight will be once it is taken.
  task automatic queue_tick(input item_t t);
    steer = advance_flight(steer, model_cfg, t);
    pending_q.push_back(t);
  endtask

  // Queues n items that keep the flight in its current phase.
  task automatic hold_phase(input int n);
    item_t   c;
    flight_t trial;
    int      tries;
    repeat (n) begin
      tries = 0;
      c     = dwell_candidate(steer);
      trial = advance_flight(steer, model_cfg, c);
      while (trial.phase != steer.phase && tries < 20) begin
        c     = dwell_candidate(steer);
        trial = advance_flight(steer, model_cfg, c);
        tries++;
      end
      if (trial.phase != steer.phase) c.pressure_ok = 1'b0;
      queue_tick(c);
    end
  endtask

  // Queues items until the flight reaches the given phase.
  task automatic fly_to(input logic [PhaseW-1:0] target);
    while (steer.phase != target) queue_tick(climb_candidate(steer));
  endtask

  // Waits until every queued item is taken and every result has come.
  task automatic wait_drained();
    while (pending_q.size() != 0 || n_taken != n_sent || due_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register and mirrors the write into the model.
  task automatic poke_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_LIFTOFF_ACCEL:  model_cfg.liftoff_accel_limit   = val[13:0];
      CFG_LIFTOFF_TICKS:  model_cfg.liftoff_confirm_ticks = val[3:0];
      CFG_BURNOUT_ACCEL:  model_cfg.burnout_accel_limit   = val[13:0];
      CFG_TILT_LIMIT:     model_cfg.tilt_limit            = val[14:0];
      CFG_APOGEE_MIN_ALT: model_cfg.apogee_min_altitude   = val[19:0];
      CFG_APOGEE_TICKS:   model_cfg.apogee_confirm_ticks  = val[3:0];
      CFG_DROGUE_ALT:     model_cfg.drogue_altitude       = val[19:0];
      CFG_MAIN_ALT:       model_cfg.main_altitude         = val[19:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A register value: an end of its range, raw bits, or anything between.
  function automatic logic [CfgDataW-1:0] pick_value(input int unsigned lo,
                                                     input int unsigned hi);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(99);
    if (r < 20) v = lo;
    else if (r < 40) v = hi;
    else if (r < 50) v = $urandom;
    else v = $urandom_range(hi, lo);
    return v[CfgDataW-1:0];
  endfunction

  // Drains the block, then rewrites every register.
  task automatic retune();
    wait_drained();
    poke_reg(CFG_LIFTOFF_ACCEL, pick_value(0, 16000));
    poke_reg(CFG_LIFTOFF_TICKS, pick_value(0, 15));
    poke_reg(CFG_BURNOUT_ACCEL, pick_value(0, 16000));
    poke_reg(CFG_TILT_LIMIT, pick_value(0, 18000));
    poke_reg(CFG_APOGEE_MIN_ALT, pick_value(0, 1000000));
    poke_reg(CFG_APOGEE_TICKS, pick_value(0, 15));
    poke_reg(CFG_DROGUE_ALT, pick_value(0, 1000000));
    poke_reg(CFG_MAIN_ALT, pick_value(0, 1000000));
    // A write beyond the last register must be ignored.
    poke_reg(CfgIdxW'(CFG_MAIN_ALT + 1 + $urandom_range(7)), CfgDataW'($urandom));
    repeat (2) @(posedge clk_i);
    steer = model_st;
  endtask

  // One or more retuned stays in the current phase, then on to the next one.
  task automatic stage(input int segs, input int calm_seg, input logic [PhaseW-1:0] next_ph);
    for (int i = 0; i < segs; i++) begin
      retune();
      calm = (i == calm_seg);
      hold_phase(HoldTicks);
    end
    wait_drained();
    calm = 1'b0;
    fly_to(next_ph);
  endtask

  // Sensor driver: presents the next pending item once the last one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (n_taken == n_sent) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
          tx_item       <= pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          n_sent++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // Monitor: predicts on every item taken and checks every result given.
  always @(posedge clk_i) begin : check_blk
    status_t           want;
    logic [PhaseW-1:0] got_phase;
    logic [FlagW-1:0]  got_flags;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        model_st   = advance_flight(model_st, model_cfg, tx_item);
        want.phase = model_st.phase;
        want.flags = model_st.flags;
        due_q.push_back(want);
        n_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_phase = m_axis_tdata[PhaseW-1:0];
        got_flags = m_axis_tdata[PhaseW+FlagW-1:PhaseW];
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual phase %0d flags %02h",
                   $time, got_phase, got_flags);
        end else begin
          want = due_q.pop_front();
          if (got_phase != want.phase) begin
            errors++;
            $display("%0t: flight_phase mismatch, expected %0d, actual %0d",
                     $time, want.phase, got_phase);
          end
          if (got_flags != want.flags) begin
            errors++;
            $display("%0t: status_bits mismatch, expected %02h, actual %02h",
                     $time, want.flags, got_flags);
          end
        end
      end
      // Watchdog on cycles in which neither stream moves an item.
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StallLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus: one whole flight, from the pad to touchdown.
  initial begin
    model_cfg.liftoff_accel_limit   = 14'd2500;
    model_cfg.liftoff_confirm_ticks = 4'd3;
    model_cfg.burnout_accel_limit   = 14'd1200;
    model_cfg.tilt_limit            = 15'd3000;
    model_cfg.apogee_min_altitude   = 20'd5000;
    model_cfg.apogee_confirm_ticks  = 4'd5;
    model_cfg.drogue_altitude       = 20'd30000;
    model_cfg.main_altitude         = 20'd10000;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // On the pad with reset settings: field extremes, invalid readings that
    // must not disturb the liftoff count, and the boundary of the threshold.
    queue_tick(sensor_tick(16777215, 32767, 32767, -32768, 1'b1, 1'b1));
    queue_tick(sensor_tick(0, 32767, 0, 0, 1'b0, 1'b1));
    queue_tick(sensor_tick(-16777216, 32767, 0, 0, 1'b1, 1'b0));
    queue_tick(sensor_tick(0, 32767, 0, 0, 1'b0, 1'b0));
    queue_tick(sensor_tick(-16777216, 2501, -32768, 32767, 1'b1, 1'b1));
    queue_tick(sensor_tick(100, 2500, 0, 0, 1'b1, 1'b1));
    queue_tick(sensor_tick(100, -32768, 0, 0, 1'b1, 1'b1));
    queue_tick(sensor_tick(200, 2501, 18000, 18000, 1'b1, 1'b1));
    queue_tick(sensor_tick(300, 2501, -18000, -18000, 1'b1, 1'b1));
    queue_tick(sensor_tick(300, 0, 0, 0, 1'b1, 1'b1));
    queue_tick(sensor_tick(-100000, 1, 18000, -18000, 1'b1, 1'b1));
    queue_tick(sensor_tick(10000000, -1, -18000, 18000, 1'b1, 1'b1));

    stage(6, 2, PH_CODE_LIFTOFF);
    stage(3, -1, PH_CODE_COAST);
    stage(6, 3, PH_CODE_DESCENT);
    stage(2, -1, PH_CODE_DROGUE);
    stage(2, -1, PH_CODE_MAIN);
    stage(3, -1, PH_CODE_LANDED);
    stage(1, -1, PH_CODE_LANDED);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
